@@ design/cpsp_pkg.sv @@
// Shared constants, path point tables, coefficient type and helpers for the
// closed-path spline position unit. No dependencies.
package cpsp_pkg;

    localparam int TIME_W        = 32;   // input position width
    localparam int POS_W         = 26;   // output coordinate width, Q9.16
    localparam int QW            = 10;   // smoothed point, quarter units
    localparam int CW            = 16;   // Hermite coefficient width, eighths
    localparam int AW            = 32;   // Horner accumulator, units of 2^-19
    localparam int UNIT_SHIFT    = 16;   // coefficient to accumulator scaling
    localparam int AXES          = 3;
    localparam int TAPS          = 4;    // keys i-1 .. i+2
    localparam int PATH_POINTS   = 24;
    localparam int KEY_COUNT_DEF = 24;
    localparam int FRAC_BITS_DEF = 16;

    localparam int PATH_X [PATH_POINTS] = '{
        0, 60, 120, 120, 120, 60, 0, 0, 0, 0, 0, 0,
        0, 0, 0, 60, 120, 120, 120, 60, 0, 0, 0, 0};
    localparam int PATH_Y [PATH_POINTS] = '{
        0, 0, 0, 60, 120, 120, 120, 120, 120, 60, 0, 0,
        0, 0, 0, 0, 0, -60, -120, -120, -120, -120, -120, -60};
    localparam int PATH_Z [PATH_POINTS] = '{
        0, 0, 0, 0, 0, 0, 0, 60, 120, 120, 120, 60,
        0, -60, -120, -120, -120, -120, -120, -120, -120, -60, 0, 0};

    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

    typedef struct packed {
        logic signed [CW-1:0] c3;
        logic signed [CW-1:0] c2;
        logic signed [CW-1:0] m0;
        logic signed [CW-1:0] s1;
    } t_coef;

    // raw path coordinate, elaboration use only
    function automatic int path_coord(input int idx, input int axis);
        int v;
        case (axis)
            AXIS_X:  v = PATH_X[idx];
            AXIS_Y:  v = PATH_Y[idx];
            AXIS_Z:  v = PATH_Z[idx];
            default: v = 0;
        endcase
        return v;
    endfunction

    // Catmull-Rom / Hermite coefficients in eighths from four smoothed points
    function automatic t_coef coef_of(input logic signed [QW-1:0] q0,
                                      input logic signed [QW-1:0] q1,
                                      input logic signed [QW-1:0] q2,
                                      input logic signed [QW-1:0] q3);
        logic signed [CW-1:0] s1;
        logic signed [CW-1:0] s2;
        logic signed [CW-1:0] m0;
        logic signed [CW-1:0] m1;
        logic signed [CW-1:0] d;
        t_coef c;
        s1   = CW'(q1) <<< 1;
        s2   = CW'(q2) <<< 1;
        m0   = CW'(q2) - CW'(q0);
        m1   = CW'(q3) - CW'(q1);
        d    = s2 - s1;
        c.c2 = d + (d <<< 1) - (m0 <<< 1) - m1;
        c.c3 = m0 + m1 - (d <<< 1);
        c.m0 = m0;
        c.s1 = s1;
        return c;
    endfunction

endpackage

@@ design/cpsp_key_wrap.sv @@
// Splits the position into key and fraction and reduces the key modulo the
// key count; emits the four wrapped keys i-1..i+2. Depends on cpsp_pkg.
module cpsp_key_wrap #(
    parameter int KEY_COUNT = cpsp_pkg::KEY_COUNT_DEF,
    parameter int FRAC_BITS = cpsp_pkg::FRAC_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_ready,
    input  logic signed [cpsp_pkg::TIME_W-1:0]       i_path_time,
    output logic                                     o_valid,
    input  logic                                     i_ready,
    output logic [cpsp_pkg::TAPS*$clog2(KEY_COUNT)-1:0] o_keys,
    output logic [FRAC_BITS-1:0]                     o_frac
);
    import cpsp_pkg::*;

    localparam int     NS    = 5;
    localparam int     W     = TIME_W - FRAC_BITS;
    localparam int     KW    = $clog2(KEY_COUNT);
    localparam int     KBW   = KW + 1;
    localparam longint MUL_L = (longint'(1) << W) / KEY_COUNT;
    localparam longint CNG_L = (longint'(1) << W) % KEY_COUNT;
    localparam logic [W-1:0]   MUL   = W'(MUL_L);
    localparam logic [KBW-1:0] K_VAL = KBW'(KEY_COUNT);
    localparam logic [KBW-1:0] CNEG  = KBW'(CNG_L);
    localparam logic [KW-1:0]  KMAX  = KW'(KEY_COUNT - 1);

    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS:0]   rdy;

    always_comb begin
        rdy[NS] = i_ready;
        for (int j = NS - 1; j >= 0; j--) begin
            rdy[j] = !r_vld[j] || rdy[j+1];
        end
        n_vld[0] = rdy[0] ? i_valid : r_vld[0];
        for (int j = 1; j < NS; j++) begin
            n_vld[j] = rdy[j] ? r_vld[j-1] : r_vld[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // stage 0: split
    logic [W-1:0]         r0_u;
    logic                 r0_neg;
    logic [FRAC_BITS-1:0] r0_f;
    // stage 1: reciprocal product
    logic [2*W-1:0]       r1_prod;
    logic [W-1:0]         r1_u;
    logic                 r1_neg;
    logic [FRAC_BITS-1:0] r1_f;
    // stage 2: quotient times key count
    logic [W-1:0]         r2_qk;
    logic [W-1:0]         r2_u;
    logic                 r2_neg;
    logic [FRAC_BITS-1:0] r2_f;
    // stage 3: remainder
    logic [KW-1:0]        r3_key;
    logic [FRAC_BITS-1:0] r3_f;
    // stage 4: neighbour keys
    logic [TAPS*KW-1:0]   r4_keys;
    logic [FRAC_BITS-1:0] r4_f;

    logic [2*W-1:0]       n1_prod;
    logic [W+KBW-1:0]     n2_qk;
    logic [W-1:0]         n3_diff;
    logic [KBW-1:0]       n3_rem;
    logic [KBW-1:0]       n3_rem1;
    logic [KBW-1:0]       n3_key;
    logic [KW-1:0]        n4_km;
    logic [KW-1:0]        n4_kp;
    logic [KBW-1:0]       n4_sum2;
    logic [KBW-1:0]       n4_kp2;

    always_comb begin
        n1_prod = (2*W)'(r0_u) * (2*W)'(MUL);
        n2_qk   = (W+KBW)'(r1_prod[2*W-1:W]) * (W+KBW)'(K_VAL);
        // reciprocal quotient may be one short: remainder below twice the count
        n3_diff = r2_u - r2_qk;
        n3_rem  = KBW'(n3_diff);
        n3_rem1 = (n3_rem >= K_VAL) ? n3_rem - K_VAL : n3_rem;
        // negative key: subtract 2^W mod count
        if (!r2_neg) begin
            n3_key = n3_rem1;
        end else if (n3_rem1 >= CNEG) begin
            n3_key = n3_rem1 - CNEG;
        end else begin
            n3_key = n3_rem1 + K_VAL - CNEG;
        end
        n4_km   = (r3_key == '0) ? KMAX : r3_key - KW'(1);
        n4_kp   = (r3_key == KMAX) ? '0 : r3_key + KW'(1);
        n4_sum2 = KBW'(r3_key) + KBW'(2);
        n4_kp2  = (n4_sum2 >= K_VAL) ? n4_sum2 - K_VAL : n4_sum2;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r0_u   <= W'(i_path_time >>> FRAC_BITS);
            r0_neg <= i_path_time[TIME_W-1];
            r0_f   <= i_path_time[FRAC_BITS-1:0];
        end
        if (rdy[1]) begin
            r1_prod <= n1_prod;
            r1_u    <= r0_u;
            r1_neg  <= r0_neg;
            r1_f    <= r0_f;
        end
        if (rdy[2]) begin
            r2_qk  <= n2_qk[W-1:0];
            r2_u   <= r1_u;
            r2_neg <= r1_neg;
            r2_f   <= r1_f;
        end
        if (rdy[3]) begin
            r3_key <= n3_key[KW-1:0];
            r3_f   <= r2_f;
        end
        if (rdy[4]) begin
            r4_keys <= {n4_kp2[KW-1:0], n4_kp, r3_key, n4_km};
            r4_f    <= r3_f;
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_vld[NS-1];
    assign o_keys  = r4_keys;
    assign o_frac  = r4_f;

endmodule

@@ design/cpsp_coef.sv @@
// Smoothed keyframe lookup and Hermite coefficient forming, two stages.
// Depends on cpsp_pkg.
module cpsp_coef #(
    parameter int KEY_COUNT = cpsp_pkg::KEY_COUNT_DEF,
    parameter int FRAC_BITS = cpsp_pkg::FRAC_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    output logic                                        o_ready,
    input  logic [cpsp_pkg::TAPS*$clog2(KEY_COUNT)-1:0] i_keys,
    input  logic [FRAC_BITS-1:0]                        i_frac,
    output logic                                        o_valid,
    input  logic                                        i_ready,
    output cpsp_pkg::t_coef [cpsp_pkg::AXES-1:0]        o_coef,
    output logic [FRAC_BITS-1:0]                        o_frac
);
    import cpsp_pkg::*;

    localparam int NS = 2;
    localparam int KW = $clog2(KEY_COUNT);

    // smoothed points in quarters, laid out key-major then axis
    function automatic logic [KEY_COUNT*AXES*QW-1:0] build_q();
        logic [KEY_COUNT*AXES*QW-1:0] tab;
        int km;
        int kp;
        int q;
        tab = '0;
        for (int k = 0; k < KEY_COUNT; k++) begin
            km = (k + KEY_COUNT - 1) % KEY_COUNT;
            kp = (k + 1) % KEY_COUNT;
            for (int a = 0; a < AXES; a++) begin
                q = 2 * path_coord(k % PATH_POINTS, a)
                  + path_coord(km % PATH_POINTS, a)
                  + path_coord(kp % PATH_POINTS, a);
                tab[(k*AXES + a)*QW +: QW] = QW'(q);
            end
        end
        return tab;
    endfunction

    localparam logic [KEY_COUNT*AXES*QW-1:0] Q_TAB = build_q();

    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS:0]   rdy;

    always_comb begin
        rdy[NS] = i_ready;
        for (int j = NS - 1; j >= 0; j--) begin
            rdy[j] = !r_vld[j] || rdy[j+1];
        end
        n_vld[0] = rdy[0] ? i_valid : r_vld[0];
        for (int j = 1; j < NS; j++) begin
            n_vld[j] = rdy[j] ? r_vld[j-1] : r_vld[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    logic signed [QW-1:0] n0_q [AXES][TAPS];
    logic signed [QW-1:0] r0_q [AXES][TAPS];
    logic [FRAC_BITS-1:0] r0_f;
    t_coef [AXES-1:0]     n1_coef;
    t_coef [AXES-1:0]     r1_coef;
    logic [FRAC_BITS-1:0] r1_f;

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            for (int j = 0; j < TAPS; j++) begin
                n0_q[a][j] = Q_TAB[(int'(i_keys[j*KW +: KW])*AXES + a)*QW +: QW];
            end
            n1_coef[a] = coef_of(r0_q[a][0], r0_q[a][1], r0_q[a][2], r0_q[a][3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r0_q <= n0_q;
            r0_f <= i_frac;
        end
        if (rdy[1]) begin
            r1_coef <= n1_coef;
            r1_f    <= r0_f;
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_vld[NS-1];
    assign o_coef  = r1_coef;
    assign o_frac  = r1_f;

endmodule

@@ design/cpsp_horner.sv @@
// Three Horner steps (multiply stage, round-and-add stage each), then the
// final round to Q9.16 with saturation. Depends on cpsp_pkg.
module cpsp_horner #(
    parameter int FRAC_BITS = cpsp_pkg::FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  cpsp_pkg::t_coef [cpsp_pkg::AXES-1:0] i_coef,
    input  logic [FRAC_BITS-1:0]                 i_frac,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [cpsp_pkg::POS_W-1:0]    o_pos_x,
    output logic signed [cpsp_pkg::POS_W-1:0]    o_pos_y,
    output logic signed [cpsp_pkg::POS_W-1:0]    o_pos_z
);
    import cpsp_pkg::*;

    localparam int NS = 7;
    localparam int PW = AW + FRAC_BITS + 1;
    localparam logic signed [PW-1:0] HALF    = PW'(longint'(1) << (FRAC_BITS - 1));
    localparam logic signed [AW-1:0] POS_MAX = AW'((longint'(1) << (POS_W - 1)) - 1);
    localparam logic signed [AW-1:0] POS_MIN = -AW'(longint'(1) << (POS_W - 1));
    localparam logic signed [AW-1:0] OUT_RND = AW'(4);

    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS:0]   rdy;

    always_comb begin
        rdy[NS] = i_ready;
        for (int j = NS - 1; j >= 0; j--) begin
            rdy[j] = !r_vld[j] || rdy[j+1];
        end
        n_vld[0] = rdy[0] ? i_valid : r_vld[0];
        for (int j = 1; j < NS; j++) begin
            n_vld[j] = rdy[j] ? r_vld[j-1] : r_vld[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    function automatic logic signed [PW-1:0] mul_f(input logic signed [AW-1:0] a,
                                                   input logic [FRAC_BITS-1:0] f);
        return PW'(a) * PW'($signed({1'b0, f}));
    endfunction

    // coefficient scaled to accumulator units plus product rounded half up
    function automatic logic signed [AW-1:0] rnd_add(input logic signed [CW-1:0] c,
                                                     input logic signed [PW-1:0] p);
        logic signed [PW-1:0] sh;
        sh = (p + HALF) >>> FRAC_BITS;
        return (AW'(c) <<< UNIT_SHIFT) + AW'(sh);
    endfunction

    logic signed [PW-1:0] r0_p [AXES];
    logic signed [AW-1:0] r1_a [AXES];
    logic signed [PW-1:0] r2_p [AXES];
    logic signed [AW-1:0] r3_a [AXES];
    logic signed [PW-1:0] r4_p [AXES];
    logic signed [AW-1:0] r5_a [AXES];
    logic signed [POS_W-1:0] r6_pos [AXES];

    t_coef [AXES-1:0] r0_cf, r1_cf, r2_cf, r3_cf, r4_cf;
    logic [FRAC_BITS-1:0] r0_f, r1_f, r2_f, r3_f;

    logic signed [PW-1:0]    n0_p [AXES];
    logic signed [AW-1:0]    n1_a [AXES];
    logic signed [PW-1:0]    n2_p [AXES];
    logic signed [AW-1:0]    n3_a [AXES];
    logic signed [PW-1:0]    n4_p [AXES];
    logic signed [AW-1:0]    n5_a [AXES];
    logic signed [AW-1:0]    n6_r [AXES];
    logic signed [POS_W-1:0] n6_pos [AXES];

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            n0_p[a] = mul_f(AW'(i_coef[a].c3) <<< UNIT_SHIFT, i_frac);
            n1_a[a] = rnd_add(r0_cf[a].c2, r0_p[a]);
            n2_p[a] = mul_f(r1_a[a], r1_f);
            n3_a[a] = rnd_add(r2_cf[a].m0, r2_p[a]);
            n4_p[a] = mul_f(r3_a[a], r3_f);
            n5_a[a] = rnd_add(r4_cf[a].s1, r4_p[a]);
            // eighths down to Q9.16, half up, then clamp
            n6_r[a] = (r5_a[a] + OUT_RND) >>> 3;
            if (n6_r[a] > POS_MAX) begin
                n6_pos[a] = POS_W'(POS_MAX);
            end else if (n6_r[a] < POS_MIN) begin
                n6_pos[a] = POS_W'(POS_MIN);
            end else begin
                n6_pos[a] = POS_W'(n6_r[a]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r0_p  <= n0_p;
            r0_cf <= i_coef;
            r0_f  <= i_frac;
        end
        if (rdy[1]) begin
            r1_a  <= n1_a;
            r1_cf <= r0_cf;
            r1_f  <= r0_f;
        end
        if (rdy[2]) begin
            r2_p  <= n2_p;
            r2_cf <= r1_cf;
            r2_f  <= r1_f;
        end
        if (rdy[3]) begin
            r3_a  <= n3_a;
            r3_cf <= r2_cf;
            r3_f  <= r2_f;
        end
        if (rdy[4]) begin
            r4_p  <= n4_p;
            r4_cf <= r3_cf;
        end
        if (rdy[5]) begin
            r5_a <= n5_a;
        end
        if (rdy[6]) begin
            r6_pos <= n6_pos;
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_vld[NS-1];
    assign o_pos_x = r6_pos[AXIS_X];
    assign o_pos_y = r6_pos[AXIS_Y];
    assign o_pos_z = r6_pos[AXIS_Z];

endmodule

@@ design/closed_path_spline_position_unit.sv @@
// Top level of the closed-path spline position unit: key wrap, coefficient
// and Horner pipelines. Depends on cpsp_pkg, cpsp_key_wrap, cpsp_coef, cpsp_horner.
//
// Usage
//   Input channel: i_valid / o_ready carry i_path_time, a signed position with
//   FRAC_BITS fraction bits. Its integer part picks the segment of a closed
//   loop of KEY_COUNT keys (negative positions floor towards minus infinity);
//   the fraction places the point along that segment.
//   Output channel: o_valid / i_ready carry o_pos_x, o_pos_y, o_pos_z, signed
//   Q9.16, one result transfer per input transfer, in order.
//   Pipeline order: key split and modulo, then table lookup and coefficients,
//   then three multiply/add Horner steps and the final round.
//   Throughput: one transfer per cycle while i_ready does not hold the output;
//   each Horner multiplier and the key reciprocal multiplier is a registered
//   stage of its own.
//   Stalls: every stage has its own valid bit and loads when it is empty or
//   its content moves on, so a held output only backs up the full stages;
//   empty stages keep taking new transfers.
//   Reset: synchronous, active low; clears all valid bits, nothing is pending
//   afterwards and o_valid is low.
module closed_path_spline_position_unit #(
    parameter int KEY_COUNT = cpsp_pkg::KEY_COUNT_DEF,
    parameter int FRAC_BITS = cpsp_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [cpsp_pkg::TIME_W-1:0] i_path_time,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [cpsp_pkg::POS_W-1:0] o_pos_x,
    output logic signed [cpsp_pkg::POS_W-1:0] o_pos_y,
    output logic signed [cpsp_pkg::POS_W-1:0] o_pos_z
);
    import cpsp_pkg::*;

    localparam int KW  = $clog2(KEY_COUNT);
    localparam int KBW = KW + 1;
    localparam logic [KBW-1:0] K_VAL = KBW'(KEY_COUNT);

    // key wrap -> coefficient
    logic                 w_key_vld;
    logic                 w_key_rdy;
    logic [TAPS*KW-1:0]   w_keys;
    logic [FRAC_BITS-1:0] w_key_frac;
    // coefficient -> Horner
    logic                 w_cf_vld;
    logic                 w_cf_rdy;
    t_coef [AXES-1:0]     w_coef;
    logic [FRAC_BITS-1:0] w_cf_frac;

    cpsp_key_wrap #(
        .KEY_COUNT (KEY_COUNT),
        .FRAC_BITS (FRAC_BITS)
    ) u_key_wrap (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_path_time (i_path_time),
        .o_valid     (w_key_vld),
        .i_ready     (w_key_rdy),
        .o_keys      (w_keys),
        .o_frac      (w_key_frac)
    );

    cpsp_coef #(
        .KEY_COUNT (KEY_COUNT),
        .FRAC_BITS (FRAC_BITS)
    ) u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_key_vld),
        .o_ready (w_key_rdy),
        .i_keys  (w_keys),
        .i_frac  (w_key_frac),
        .o_valid (w_cf_vld),
        .i_ready (w_cf_rdy),
        .o_coef  (w_coef),
        .o_frac  (w_cf_frac)
    );

    cpsp_horner #(
        .FRAC_BITS (FRAC_BITS)
    ) u_horner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cf_vld),
        .o_ready (w_cf_rdy),
        .i_coef  (w_coef),
        .i_frac  (w_cf_frac),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_pos_x (o_pos_x),
        .o_pos_y (o_pos_y),
        .o_pos_z (o_pos_z)
    );

    // wrapped keys never leave the table
    a_key_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_key_vld |-> ({1'b0, w_keys[KW-1:0]} < K_VAL)
                   && ({1'b0, w_keys[2*KW-1:KW]} < K_VAL)
                   && ({1'b0, w_keys[3*KW-1:2*KW]} < K_VAL)
                   && ({1'b0, w_keys[4*KW-1:3*KW]} < K_VAL))
        else $error("wrapped key out of range");

    // empty output stage means every stage upstream can load
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with output stage empty");

    // nothing pending straight after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid && !w_key_vld && !w_cf_vld)
        else $error("valid bits survive reset");

endmodule
